[rtl/jsu_pkg.sv]
// shared types and constants for the json string unescape block
`default_nettype none

package jsu_pkg;

   // result kinds as carried on rsp_tuser
   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_END  = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;

   // default number of result groups held between front and back
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // one group of results caused by one input item, bytes[0] goes out first
   typedef struct packed {
      logic [1:0]      kind;
      logic [1:0]      last_idx;
      logic [3:0][7:0] bytes;
   } jsu_entry_type;

endpackage

`default_nettype wire

[rtl/json_string_unescape_utf8_core.sv]
// top level of the streaming json string unescape to utf-8 decoder
`default_nettype none

// Decodes one strict quoted JSON string at a time, one raw byte per input
// item on the req_ channel, and delivers decoded UTF-8 bytes, an end mark or
// an error mark on the rsp_ channel. A byte is taken every cycle as long as
// the result queue has room; it is parsed in the cycle it is accepted and
// turned into a group of zero to four results. The back end sends one result
// item per cycle while rsp_tready is high, so a \u escape that expands to four
// bytes holds the back end while the queue of QUEUE_DEPTH groups absorbs the
// burst. The first result of an accepted byte is written to the queue, then
// to the registered output stage. rsp_tlast marks each group's final result.
// After an end or an error result the decoder waits for a new opening quote.

module json_string_unescape_utf8_core #(
   parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   // input items
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   // result items
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [1:0] rsp_tuser,   // [1:0] kind
   output logic       rsp_tlast
);
   import jsu_pkg::*;

   logic          queue_full;
   logic          queue_empty;
   logic          push;
   logic          pop;
   jsu_entry_type push_entry;
   jsu_entry_type head_entry;

   // parser, one byte per cycle while the queue has room
   jsu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // groups of results waiting for the back end
   jsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .empty      (queue_empty),
      .head_entry (head_entry)
   );

   // serializer with the registered output stage
   jsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (!queue_empty),
      .head_entry (head_entry),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_byte   (rsp_tdata),
      .out_kind   (rsp_tuser),
      .out_last   (rsp_tlast)
   );

endmodule

`default_nettype wire

[rtl/jsu_front.sv]
// front end: string parser that turns each input byte into a result group
`default_nettype none

module jsu_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [7:0]            in_byte,
   input  logic                  queue_full,
   output logic                  push,
   output jsu_pkg::jsu_entry_type push_entry
);
   import jsu_pkg::*;

   typedef enum logic [3:0] {
      PH_WAIT,
      PH_BODY,
      PH_ESC,
      PH_HEX1,
      PH_BSL,
      PH_U,
      PH_HEX2
   } phase_type;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_N     = 8'h6E;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_U     = 8'h75;

   localparam logic [15:0] HIGH_MIN = 16'hD800;
   localparam logic [15:0] HIGH_MAX = 16'hDBFF;
   localparam logic [15:0] LOW_MIN  = 16'hDC00;
   localparam logic [15:0] LOW_MAX  = 16'hDFFF;
   localparam logic [20:0] PLANE1   = 21'h10000;

   // {valid, nibble}
   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      logic [4:0] r;
      r = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

   function automatic jsu_entry_type utf8_encode(input logic [20:0] cp);
      jsu_entry_type e;
      e = '0;
      e.kind = KIND_BYTE;
      if (cp <= 21'h7F) begin
         e.bytes[0] = cp[7:0];
      end else if (cp <= 21'h7FF) begin
         e.last_idx = 2'd1;
         e.bytes[0] = 8'hC0 | {3'b000, cp[10:6]};
         e.bytes[1] = 8'h80 | {2'b00, cp[5:0]};
      end else if (cp <= 21'hFFFF) begin
         e.last_idx = 2'd2;
         e.bytes[0] = 8'hE0 | {4'b0000, cp[15:12]};
         e.bytes[1] = 8'h80 | {2'b00, cp[11:6]};
         e.bytes[2] = 8'h80 | {2'b00, cp[5:0]};
      end else begin
         e.last_idx = 2'd3;
         e.bytes[0] = 8'hF0 | {5'b00000, cp[20:18]};
         e.bytes[1] = 8'h80 | {2'b00, cp[17:12]};
         e.bytes[2] = 8'h80 | {2'b00, cp[11:6]};
         e.bytes[3] = 8'h80 | {2'b00, cp[5:0]};
      end
      return e;
   endfunction

   phase_type     phase_ff, phase_in;
   logic [15:0]   accum_ff, accum_in;
   logic [1:0]    digits_ff, digits_in;
   logic [9:0]    high_ff, high_in;

   logic          accept;
   logic          emit;
   logic          do_fail;
   logic [4:0]    hexv;
   logic [15:0]   accum_next;
   logic [20:0]   cp_pair;
   jsu_entry_type entry;

   assign in_ready   = !queue_full;
   assign accept     = in_valid && !queue_full;
   assign hexv       = hex_nibble(in_byte);
   assign accum_next = {accum_ff[11:0], hexv[3:0]};
   assign cp_pair    = PLANE1 + {1'b0, high_ff, accum_next[9:0]};

   always_comb begin
      phase_in  = phase_ff;
      accum_in  = accum_ff;
      digits_in = digits_ff;
      high_in   = high_ff;
      emit      = 1'b0;
      do_fail   = 1'b0;
      entry     = '0;
      entry.kind = KIND_BYTE;

      case (phase_ff)
         PH_WAIT: begin
            if (in_byte != CH_QUOTE) begin
               do_fail = 1'b1;
            end else begin
               phase_in = PH_BODY;
            end
         end
         PH_BODY: begin
            if (in_byte == CH_NUL) begin
               do_fail = 1'b1;
            end else if (in_byte == CH_QUOTE) begin
               phase_in   = PH_WAIT;
               emit       = 1'b1;
               entry.kind = KIND_END;
            end else if (in_byte < CH_SPACE) begin
               do_fail = 1'b1;
            end else if (in_byte == CH_BSL) begin
               phase_in = PH_ESC;
            end else begin
               emit           = 1'b1;
               entry.bytes[0] = in_byte;
            end
         end
         PH_ESC: begin
            phase_in = PH_BODY;
            emit     = 1'b1;
            case (in_byte)
               CH_QUOTE, CH_BSL, CH_SLASH: entry.bytes[0] = in_byte;
               CH_B: entry.bytes[0] = 8'h08;
               CH_F: entry.bytes[0] = 8'h0C;
               CH_N: entry.bytes[0] = 8'h0A;
               CH_R: entry.bytes[0] = 8'h0D;
               CH_T: entry.bytes[0] = 8'h09;
               CH_U: begin
                  emit      = 1'b0;
                  phase_in  = PH_HEX1;
                  accum_in  = '0;
                  digits_in = '0;
               end
               default: begin
                  emit    = 1'b0;
                  do_fail = 1'b1;
               end
            endcase
         end
         PH_BSL: begin
            if (in_byte != CH_BSL) begin
               do_fail = 1'b1;
            end else begin
               phase_in = PH_U;
            end
         end
         PH_U: begin
            if (in_byte != CH_U) begin
               do_fail = 1'b1;
            end else begin
               phase_in  = PH_HEX2;
               accum_in  = '0;
               digits_in = '0;
            end
         end
         PH_HEX1, PH_HEX2: begin
            if (!hexv[4]) begin
               do_fail = 1'b1;
            end else if (digits_ff != 2'd3) begin
               accum_in  = accum_next;
               digits_in = digits_ff + 2'd1;
            end else begin
               accum_in  = accum_next;
               digits_in = '0;
               if (phase_ff == PH_HEX1) begin
                  if (accum_next >= HIGH_MIN && accum_next <= HIGH_MAX) begin
                     high_in  = accum_next[9:0];
                     phase_in = PH_BSL;
                  end else if (accum_next >= LOW_MIN && accum_next <= LOW_MAX) begin
                     do_fail = 1'b1;
                  end else begin
                     phase_in = PH_BODY;
                     emit     = 1'b1;
                     entry    = utf8_encode({5'b00000, accum_next});
                  end
               end else begin
                  if (accum_next < LOW_MIN || accum_next > LOW_MAX) begin
                     do_fail = 1'b1;
                  end else begin
                     high_in  = '0;
                     phase_in = PH_BODY;
                     emit     = 1'b1;
                     entry    = utf8_encode(cp_pair);
                  end
               end
            end
         end
         default: begin
            do_fail = 1'b1;
         end
      endcase

      if (do_fail) begin
         phase_in   = PH_WAIT;
         accum_in   = '0;
         digits_in  = '0;
         high_in    = '0;
         emit       = 1'b1;
         entry      = '0;
         entry.kind = KIND_ERR;
      end
   end

   assign push       = accept && emit;
   assign push_entry = entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_WAIT;
         accum_ff  <= '0;
         digits_ff <= '0;
         high_ff   <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         accum_ff  <= accum_in;
         digits_ff <= digits_in;
         high_ff   <= high_in;
      end
   end

endmodule

`default_nettype wire

[rtl/jsu_queue.sv]
// short first-in first-out queue of result groups between front and back
`default_nettype none

module jsu_queue #(
   parameter int DEPTH = jsu_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  jsu_pkg::jsu_entry_type push_entry,
   output logic                  full,
   input  logic                  pop,
   output logic                  empty,
   output jsu_pkg::jsu_entry_type head_entry
);
   import jsu_pkg::*;

   // depth is a power of two, at least two
   localparam int AW = $clog2(DEPTH);

   jsu_entry_type slots_ff [DEPTH];
   logic [AW:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW:0]   rd_ptr_ff, rd_ptr_in;

   assign empty      = (wr_ptr_ff == rd_ptr_ff);
   assign full       = (wr_ptr_ff[AW] != rd_ptr_ff[AW]) &&
                       (wr_ptr_ff[AW-1:0] == rd_ptr_ff[AW-1:0]);
   assign head_entry = slots_ff[rd_ptr_ff[AW-1:0]];
   assign wr_ptr_in  = wr_ptr_ff + {{AW{1'b0}}, (push && !full)};
   assign rd_ptr_in  = rd_ptr_ff + {{AW{1'b0}}, (pop && !empty)};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         slots_ff[wr_ptr_ff[AW-1:0]] <= push_entry;
      end
   end

endmodule

`default_nettype wire

[rtl/jsu_back.sv]
// back end: sends the bytes of each result group out one item per cycle while out_ready does not stall it
`default_nettype none

module jsu_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  jsu_pkg::jsu_entry_type head_entry,
   output logic                  pop,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [7:0]            out_byte,
   output logic [1:0]            out_kind,
   output logic                  out_last
);
   import jsu_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic [1:0] kind_ff, kind_in;
   logic       last_ff, last_in;
   logic       load;
   logic       at_last;

   assign load    = !valid_ff || out_ready;
   assign at_last = (idx_ff == head_entry.last_idx);
   assign pop     = load && head_valid && at_last;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      kind_in  = kind_ff;
      last_in  = last_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = head_valid;
         byte_in  = head_entry.bytes[idx_ff];
         kind_in  = head_entry.kind;
         last_in  = at_last;
         if (head_valid) begin
            idx_in = at_last ? 2'd0 : idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      kind_ff <= kind_in;
      last_ff <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_kind  = kind_ff;
   assign out_last  = last_ff;

endmodule

`default_nettype wire
